// ----- sv/stochastic_rounding_quantizer_unit_defines.svh -----
`ifndef STOCHASTIC_ROUNDING_QUANTIZER_UNIT_DEFINES_SVH
`define STOCHASTIC_ROUNDING_QUANTIZER_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define SRQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srq check failed");

// next-cycle implication under reset
`define SRQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srq check failed");

`endif

// ----- sv/srq_pkg.sv -----
`timescale 1ns / 1ps

package srq_pkg;

    localparam int INDEX_BITS_DEF = 32;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    localparam logic [31:0] STEP_RESET = 32'h3F800000;
    localparam logic [63:0] SEED_RESET = 64'h0;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED  = 2'd1;

    localparam int MANT_W   = 24;
    localparam int EXP_W    = 10;
    localparam int DIV_BITS = 55;
    localparam int U_W      = 53;
    localparam int FIX_W    = 86;

    // stage map: unpack, one stage per quotient bit, round, align, two finish stages
    localparam int ST_FIN1    = DIV_BITS + 3;
    localparam int NUM_STAGES = DIV_BITS + 5;
    localparam int HASH_LAST  = 5;

    typedef enum logic [1:0] {
        CLS_NORMAL,
        CLS_ZERO,
        CLS_INF,
        CLS_NAN
    } quot_class_t;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic [31:0] element_index;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] quant_code;
        logic               saturated;
        logic               invalid;
        logic               is_last_out;
    } out_item_t;

    typedef struct packed {
        quot_class_t              cls;
        logic                     sign;
        logic signed [EXP_W-1:0]  exp;
        logic                     is_last;
    } quot_side_t;

endpackage

// ----- sv/srq_hash.sv -----
`timescale 1ns / 1ps

module srq_hash #(
    parameter int INDEX_BITS = srq_pkg::INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  advance,
    input  logic [31:0]           element_index,
    input  logic [63:0]           seed,
    output logic [srq_pkg::U_W-1:0] uniform
);
    import srq_pkg::*;

    localparam logic [63:0] CNT_MASK =
        (INDEX_BITS >= 64) ? {64{1'b1}} : ((64'd1 << INDEX_BITS) - 64'd1);
    localparam int U_DELAY = ST_FIN1 - HASH_LAST;

    logic [63:0] cnt;
    logic [63:0] pl0_next, pl2_next, pl4_next;
    logic [31:0] pa0_next, pb0_next, pa2_next, pb2_next, pa4_next, pb4_next;
    logic [63:0] pl0_reg, pl2_reg, pl4_reg;
    logic [31:0] pa0_reg, pb0_reg, pa2_reg, pb2_reg, pa4_reg, pb4_reg;
    logic [63:0] z1, z3, z5;
    logic [63:0] y1_next, y3_next, y5;
    logic [63:0] y1_reg, y3_reg;
    logic [U_W-1:0] u_dly_reg [0:U_DELAY];

    assign cnt = {32'b0, element_index} & CNT_MASK;

    // low 64 bits of each product from three 32x32 partials
    assign pl0_next = {32'b0, cnt[31:0]} * {32'b0, GOLDEN_GAMMA[31:0]};
    assign pa0_next = cnt[63:32] * GOLDEN_GAMMA[31:0];
    assign pb0_next = cnt[31:0] * GOLDEN_GAMMA[63:32];

    assign z1      = seed + pl0_reg + {pa0_reg + pb0_reg, 32'b0};
    assign y1_next = z1 ^ (z1 >> 30);

    assign pl2_next = {32'b0, y1_reg[31:0]} * {32'b0, MIX_MUL_A[31:0]};
    assign pa2_next = y1_reg[63:32] * MIX_MUL_A[31:0];
    assign pb2_next = y1_reg[31:0] * MIX_MUL_A[63:32];

    assign z3      = pl2_reg + {pa2_reg + pb2_reg, 32'b0};
    assign y3_next = z3 ^ (z3 >> 27);

    assign pl4_next = {32'b0, y3_reg[31:0]} * {32'b0, MIX_MUL_B[31:0]};
    assign pa4_next = y3_reg[63:32] * MIX_MUL_B[31:0];
    assign pb4_next = y3_reg[31:0] * MIX_MUL_B[63:32];

    assign z5 = pl4_reg + {pa4_reg + pb4_reg, 32'b0};
    assign y5 = z5 ^ (z5 >> 31);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pl0_reg <= pl0_next;
            pa0_reg <= pa0_next;
            pb0_reg <= pb0_next;
            y1_reg  <= y1_next;
            pl2_reg <= pl2_next;
            pa2_reg <= pa2_next;
            pb2_reg <= pb2_next;
            y3_reg  <= y3_next;
            pl4_reg <= pl4_next;
            pa4_reg <= pa4_next;
            pb4_reg <= pb4_next;
            u_dly_reg[0] <= y5[63:11];
            for (int j = 1; j <= U_DELAY; j++)
            begin
                u_dly_reg[j] <= u_dly_reg[j-1];
            end
        end
    end

    assign uniform = u_dly_reg[U_DELAY];

endmodule

// ----- sv/srq_divider.sv -----
`timescale 1ns / 1ps

module srq_divider (
    input  logic                           clk,
    input  logic                           advance,
    input  logic [31:0]                    sample_bits,
    input  logic [31:0]                    step_bits,
    input  logic                           is_last,
    output logic [srq_pkg::DIV_BITS-1:0]   quot,
    output logic                           rem_nz,
    output srq_pkg::quot_side_t            side
);
    import srq_pkg::*;

    function automatic logic [5:0] lead_zeros(input logic [MANT_W-1:0] m);
        logic [5:0] n;
        n = 6'(MANT_W);
        for (int i = 0; i < MANT_W; i++)
        begin
            if (m[i])
            begin
                n = 6'(MANT_W - 1 - i);
            end
        end
        return n;
    endfunction

    logic              sa, sb;
    logic [7:0]        ea, eb;
    logic [22:0]       fa, fb;
    logic              a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [MANT_W-1:0] ma_raw, mb_raw;
    logic [5:0]        lza, lzb;
    logic signed [EXP_W-1:0] exp_a, exp_b;
    quot_side_t        side0_next;

    logic [MANT_W:0]     rem_reg  [0:DIV_BITS];
    logic [MANT_W-1:0]   dvs_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] q_reg    [0:DIV_BITS];
    quot_side_t          side_reg [0:DIV_BITS];

    assign {sa, ea, fa} = sample_bits;
    assign {sb, eb, fb} = step_bits;

    assign a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    assign a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    assign a_zero = (ea == 8'h00) && (fa == 23'd0);
    assign b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    assign b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    assign b_zero = (eb == 8'h00) && (fb == 23'd0);

    assign ma_raw = {(ea != 8'h00), fa};
    assign mb_raw = {(eb != 8'h00), fb};
    assign lza    = lead_zeros(ma_raw);
    assign lzb    = lead_zeros(mb_raw);

    // subnormals get normalized so the quotient always lands in (1/2, 2)
    assign exp_a = (ea == 8'h00) ? (-10'sd126 - signed'({4'b0000, lza}))
                                 : (signed'({2'b00, ea}) - 10'sd127);
    assign exp_b = (eb == 8'h00) ? (-10'sd126 - signed'({4'b0000, lzb}))
                                 : (signed'({2'b00, eb}) - 10'sd127);

    always_comb
    begin
        side0_next.sign    = sa ^ sb;
        side0_next.exp     = exp_a - exp_b;
        side0_next.is_last = is_last;
        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
        begin
            side0_next.cls = CLS_NAN;
        end
        else if (a_inf || b_zero)
        begin
            side0_next.cls = CLS_INF;
        end
        else if (a_zero || b_inf)
        begin
            side0_next.cls = CLS_ZERO;
        end
        else
        begin
            side0_next.cls = CLS_NORMAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= {1'b0, ma_raw << lza};
            dvs_reg[0]  <= mb_raw << lzb;
            q_reg[0]    <= '0;
            side_reg[0] <= side0_next;
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_div
        logic            ge;
        logic [MANT_W:0] part;

        assign ge   = rem_reg[k-1] >= {1'b0, dvs_reg[k-1]};
        assign part = ge ? (rem_reg[k-1] - {1'b0, dvs_reg[k-1]}) : rem_reg[k-1];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= {part[MANT_W-1:0], 1'b0};
                dvs_reg[k]  <= dvs_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][DIV_BITS-2:0], ge};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign quot   = q_reg[DIV_BITS];
    assign rem_nz = |rem_reg[DIV_BITS];
    assign side   = side_reg[DIV_BITS];

endmodule

// ----- sv/srq_finish.sv -----
`timescale 1ns / 1ps

module srq_finish (
    input  logic                         clk,
    input  logic                         advance,
    input  logic [srq_pkg::DIV_BITS-1:0] quot,
    input  logic                         rem_nz,
    input  srq_pkg::quot_side_t          side,
    input  logic [srq_pkg::U_W-1:0]      uniform,
    output srq_pkg::out_item_t           result
);
    import srq_pkg::*;

    // round stage
    logic [52:0]             mant_t;
    logic                    rg, rs, rinc;
    logic [53:0]             rsum;
    logic [52:0]             mant_next;
    quot_side_t              rside_next;
    logic [52:0]             mant_reg;
    quot_side_t              rside_reg;

    // align stage
    logic                    big, tiny;
    logic signed [EXP_W-1:0] sh_full;
    logic [141:0]            zwide;
    logic [FIX_W-1:0]        fix_next;
    logic                    stk_next;
    logic [FIX_W-1:0]        fix_reg;
    logic                    stk_reg;
    logic                    big_reg;
    quot_side_t              aside_reg;

    // first finish stage
    logic [30:0]             int_p;
    logic [52:0]             kf;
    logic                    fg, fs, nz;
    logic [53:0]             rneg;
    logic [31:0]             base_next;
    logic [53:0]             c_next;
    logic                    sat_next, inv_next;
    logic [31:0]             base_reg;
    logic [53:0]             c_reg;
    logic                    sat_reg, inv_reg, last_reg;

    logic                    up;
    out_item_t               result_next;
    out_item_t               result_reg;

    always_comb
    begin
        rside_next = side;
        if (quot[DIV_BITS-1])
        begin
            mant_t = quot[DIV_BITS-1:2];
            rg     = quot[1];
            rs     = quot[0] | rem_nz;
        end
        else
        begin
            mant_t = quot[DIV_BITS-2:1];
            rg     = quot[0];
            rs     = rem_nz;
            rside_next.exp = side.exp - 10'sd1;
        end
        rinc = rg & (rs | mant_t[0]);
        rsum = {1'b0, mant_t} + {53'b0, rinc};
        if (rsum[53])
        begin
            mant_next      = rsum[53:1];
            rside_next.exp = rside_next.exp + 10'sd1;
        end
        else
        begin
            mant_next = rsum[52:0];
        end
    end

    // |x| as fixed point: 31 integer bits, 53 fraction bits, guard, sticky
    assign big     = rside_reg.exp >= 10'sd31;
    assign tiny    = rside_reg.exp < -10'sd59;
    assign sh_full = rside_reg.exp + 10'sd59;
    assign zwide   = {89'b0, mant_reg} << sh_full[6:0];

    always_comb
    begin
        if (tiny)
        begin
            fix_next = '0;
            stk_next = 1'b1;
        end
        else
        begin
            fix_next = zwide[141:56];
            stk_next = |zwide[55:0];
        end
    end

    assign int_p = fix_reg[85:55];
    assign kf    = fix_reg[54:2];
    assign fg    = fix_reg[1];
    assign fs    = fix_reg[0] | stk_reg;
    assign nz    = (|kf) | fg | fs;
    assign rneg  = {1'b0, kf} + {53'b0, fg & (fs | kf[0])};

    always_comb
    begin
        base_next = 32'd0;
        c_next    = '0;
        sat_next  = 1'b0;
        inv_next  = 1'b0;
        case (aside_reg.cls)
            CLS_NAN:
            begin
                inv_next = 1'b1;
            end
            CLS_INF:
            begin
                sat_next  = 1'b1;
                base_next = aside_reg.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            CLS_ZERO:
            begin
                base_next = 32'd0;
            end
            CLS_NORMAL:
            begin
                if (aside_reg.sign)
                begin
                    if (big_reg)
                    begin
                        sat_next  = 1'b1;
                        base_next = 32'h8000_0000;
                    end
                    else
                    begin
                        base_next = nz ? ~{1'b0, int_p} : -{1'b0, int_p};
                        c_next    = nz ? ({1'b1, 53'b0} - rneg) : 54'd0;
                    end
                end
                else
                begin
                    if (big_reg || (int_p == 31'h7FFF_FFFF))
                    begin
                        sat_next  = 1'b1;
                        base_next = 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        base_next = {1'b0, int_p};
                        c_next    = {1'b0, kf} + {53'b0, fg | fs};
                    end
                end
            end
            default:
            begin
                inv_next = 1'b1;
            end
        endcase
    end

    assign up = {1'b0, uniform} < c_reg;

    always_comb
    begin
        result_next.quant_code  = signed'(base_reg + {31'b0, up});
        result_next.saturated   = sat_reg;
        result_next.invalid     = inv_reg;
        result_next.is_last_out = last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mant_reg   <= mant_next;
            rside_reg  <= rside_next;
            fix_reg    <= fix_next;
            stk_reg    <= stk_next;
            big_reg    <= big;
            aside_reg  <= rside_reg;
            base_reg   <= base_next;
            c_reg      <= c_next;
            sat_reg    <= sat_next;
            inv_reg    <= inv_next;
            last_reg   <= aside_reg.is_last;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- sv/stochastic_rounding_quantizer_unit.sv -----
// stochastic rounding quantizer
// in channel: in_valid / in_ready with in_data (sample float32 bits, element index,
// last flag). out channel: out_valid / out_ready with out_data (signed code,
// saturated, invalid, last copy). cfg channel: cfg_valid / cfg_ready with
// cfg_index and cfg_data; index 0 writes the float32 step, index 1 the 64-bit
// seed, other indexes are dropped. cfg_ready is always high; write only when idle.
// throughput: one transaction per cycle while the skid register is empty. results
// pass through the 55-stage radix-2 quotient pipeline plus unpack, round, align
// and two finish stages; the 64-bit hash runs beside it in six stages.
// reset: pipeline and skid stage empty, step = 1.0, seed = 0.
// stall: when out_ready is low the shown result moves into a skid register and
// the pipeline keeps advancing for that cycle; while the skid register is full
// the whole pipeline holds and in_ready is low. nothing is dropped or repeated.
`timescale 1ns / 1ps

module stochastic_rounding_quantizer_unit #(
    parameter int INDEX_BITS = srq_pkg::INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  srq_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output srq_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data
);
    import srq_pkg::*;

    logic [31:0]           step_reg, step_next;
    logic [63:0]           seed_reg, seed_next;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    out_item_t             skid_data_reg;
    logic                  advance;

    logic [DIV_BITS-1:0]   quot;
    logic                  rem_nz;
    quot_side_t            side;
    logic [U_W-1:0]        uniform;
    out_item_t             pipe_out;

    assign cfg_ready = 1'b1;
    assign advance   = !skid_valid_reg;
    assign in_ready  = advance;

    always_comb
    begin
        step_next = step_reg;
        seed_next = seed_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEP_SIZE: step_next = cfg_data[31:0];
                REG_RNG_SEED:  seed_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};
        end
        if (skid_valid_reg)
        begin
            skid_valid_next = !out_ready;
        end
        else
        begin
            skid_valid_next = valid_reg[NUM_STAGES-1] && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_RESET;
            seed_reg       <= SEED_RESET;
            valid_reg      <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            seed_reg       <= seed_next;
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_data_reg <= pipe_out;
        end
    end

    srq_divider u_divider (
        .clk         (clk),
        .advance     (advance),
        .sample_bits (in_data.sample_bits),
        .step_bits   (step_reg),
        .is_last     (in_data.is_last),
        .quot        (quot),
        .rem_nz      (rem_nz),
        .side        (side)
    );

    srq_hash #(
        .INDEX_BITS (INDEX_BITS)
    ) u_hash (
        .clk           (clk),
        .advance       (advance),
        .element_index (in_data.element_index),
        .seed          (seed_reg),
        .uniform       (uniform)
    );

    srq_finish u_finish (
        .clk     (clk),
        .advance (advance),
        .quot    (quot),
        .rem_nz  (rem_nz),
        .side    (side),
        .uniform (uniform),
        .result  (pipe_out)
    );

    assign out_valid = skid_valid_reg || valid_reg[NUM_STAGES-1];
    assign out_data  = skid_valid_reg ? skid_data_reg : pipe_out;

endmodule

// ----- sv/srq_checker.sv -----
`timescale 1ns / 1ps
`include "stochastic_rounding_quantizer_unit_defines.svh"

module srq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input srq_pkg::out_item_t out_data
);
    import srq_pkg::*;

    // a held result stays put
    `SRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // input only backs up after a stalled result
    `SRQ_ASSERT_NOW(a_in_stall, clk, rst_n, !in_ready, $past(out_valid && !out_ready))

    // nan quotient carries a zero code and no saturation
    `SRQ_ASSERT_NOW(a_nan_code, clk, rst_n, out_valid && out_data.invalid, (out_data.quant_code == 32'sd0) && !out_data.saturated)

    // saturation only ever shows an int32 limit
    `SRQ_ASSERT_NOW(a_sat_code, clk, rst_n, out_valid && out_data.saturated, (out_data.quant_code == 32'h7FFF_FFFF) || (out_data.quant_code == 32'h8000_0000))

endmodule

bind stochastic_rounding_quantizer_unit srq_checker u_srq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/srq_code_checker.sv -----
`timescale 1ns / 1ps

module srq_code_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  srq_pkg::in_item_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  srq_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [srq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import srq_pkg::*;

    logic [31:0] step_bits;
    logic [63:0] seed;
    out_item_t   code_queue[$];

    // float32 bits to a double, finite values only
    function automatic real f32_value(logic [31:0] b);
        logic [22:0] frac;
        logic [23:0] m;
        int          e;
        frac = b[22:0];
        m = {1'b1, frac};
        e = int'(b[30:23]) - 127;
        if (b[30:23] == 8'd0)
        begin
            m = {1'b0, frac};
            e = -126;
            if (frac == 23'd0)
                return b[31] ? -0.0 : 0.0;
            while (!m[23])
            begin
                m = m << 1;
                e = e - 1;
            end
        end
        return $bitstoreal({b[31], 11'(e + 1023), m[22:0], 29'd0});
    endfunction

    function automatic real splitmix_uniform(logic [63:0] s, logic [31:0] idx);
        logic [63:0] z;
        z = s + GOLDEN_GAMMA * {32'd0, idx};
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        z = z ^ (z >> 31);
        return real'(z >> 11) / 9007199254740992.0;
    endfunction

    function automatic out_item_t predict_code(in_item_t it);
        out_item_t r;
        logic      s_nan, s_inf, s_zero, t_nan, t_inf, t_zero, neg;
        real       x;
        longint    fl;
        r = '0;
        r.is_last_out = it.is_last;
        s_nan  = (it.sample_bits[30:23] == 8'hFF) && (it.sample_bits[22:0] != 0);
        s_inf  = (it.sample_bits[30:23] == 8'hFF) && (it.sample_bits[22:0] == 0);
        s_zero = (it.sample_bits[30:0] == 0);
        t_nan  = (step_bits[30:23] == 8'hFF) && (step_bits[22:0] != 0);
        t_inf  = (step_bits[30:23] == 8'hFF) && (step_bits[22:0] == 0);
        t_zero = (step_bits[30:0] == 0);
        neg = it.sample_bits[31] ^ step_bits[31];
        if (s_nan || t_nan || (s_zero && t_zero) || (s_inf && t_inf))
        begin
            r.invalid = 1'b1;
        end
        else if (s_inf || t_zero)
        begin
            r.saturated = 1'b1;
            r.quant_code = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else if (s_zero || t_inf)
        begin
            r.quant_code = '0;
        end
        else
        begin
            x = f32_value(it.sample_bits) / f32_value(step_bits);
            if (x >= 2147483647.0)
            begin
                r.saturated = 1'b1;
                r.quant_code = 32'sh7FFFFFFF;
            end
            else if (x <= -2147483648.0)
            begin
                r.saturated = 1'b1;
                r.quant_code = 32'sh80000000;
            end
            else
            begin
                fl = longint'($rtoi(x));
                if (real'(fl) > x)
                    fl = fl - 1;
                if (splitmix_uniform(seed, it.element_index) < (x - real'(fl)))
                    fl = fl + 1;
                r.quant_code = fl[31:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            step_bits  <= STEP_RESET;
            seed       <= SEED_RESET;
            fail_count <= 0;
            code_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (code_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = code_queue.pop_front();
                    if (want.quant_code !== out_data.quant_code)
                        $display("%0t: quant_code expected %0d actual %0d", $time,
                                 want.quant_code, out_data.quant_code);
                    if (want.saturated !== out_data.saturated)
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, out_data.saturated);
                    if (want.invalid !== out_data.invalid)
                        $display("%0t: invalid expected %b actual %b", $time,
                                 want.invalid, out_data.invalid);
                    if (want.is_last_out !== out_data.is_last_out)
                        $display("%0t: is_last_out expected %b actual %b", $time,
                                 want.is_last_out, out_data.is_last_out);
                    if (want !== out_data)
                        fail_count <= fail_count + 1;
                end
            end
            if (in_valid && in_ready)
                code_queue.push_back(predict_code(in_data));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_STEP_SIZE)
                    step_bits <= cfg_data[31:0];
                else if (cfg_index == REG_RNG_SEED)
                    seed <= cfg_data;
            end
        end
    end

    assign pending = code_queue.size();

endmodule

// ----- tb/stochastic_rounding_quantizer_unit_tb.sv -----
`timescale 1ns / 1ps

module stochastic_rounding_quantizer_unit_tb;
    import srq_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    int                   fail_count;
    int                   pending;
    logic                 hold_go = 1'b0;
    int                   burst_left = 0;

    localparam int LATENCY = 70;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stochastic_rounding_quantizer_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    srq_code_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: one long hold-off on request, otherwise a rotating stall pattern
    always @(posedge clk)
    begin
        int hold_cnt;
        int cyc;
        if (hold_go && hold_cnt < 250)
        begin
            hold_cnt = hold_cnt + 1;
            out_ready <= 1'b0;
        end
        else
        begin
            cyc = cyc + 1;
            case ((cyc / 97) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] b;
        b = $urandom();
        case ($urandom_range(0, 9))
            0: ;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: b[30:0] = 31'h7F800000;
                    1: b[30:23] = 8'hFF;
                    2: b[30:0] = '0;
                    default: b[30:23] = 8'h00;
                endcase
            end
            default: b[30:23] = 8'($urandom_range(110, 158));
        endcase
        return b;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    logic [31:0] edge_samples[22] = '{
        32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
        32'hFFFFFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001, 32'h80000001,
        32'h3FC00000, 32'hBFC00000, 32'h4F000000, 32'hCF000000, 32'h4EFFFFFF,
        32'hCEFFFFFF, 32'h3F000000, 32'hBF000000, 32'h40200000, 32'h4B7FFFFF,
        32'h3F7FFFFF, 32'hC0200000
    };

    logic [31:0] phase_step[10] = '{
        32'h3F800000, 32'h3E800000, 32'h40490FDB, 32'hC0000000, 32'h00000001,
        32'h7F7FFFFF, 32'h00000000, 32'h7F800000, 32'h7FC00000, 32'h3A83126F
    };
    int phase_items[10] = '{300, 250, 250, 250, 60, 60, 40, 40, 40, 250};

    initial
    begin
        in_item_t it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge values with the reset step and seed
        foreach (edge_samples[i])
        begin
            it.sample_bits   = edge_samples[i];
            it.element_index = (i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hFFFFFFFF : $urandom();
            it.is_last       = i[0];
            send_item(it);
        end
        drain();

        for (int p = 0; p < 11; p++)
        begin
            if (p < 10)
            begin
                write_reg(REG_STEP_SIZE, {32'd0, phase_step[p]});
                write_reg(REG_RNG_SEED, (p == 1) ? 64'hFFFFFFFFFFFFFFFF :
                                        (p == 2) ? 64'h0 : rand64());
            end
            else
            begin
                // out-of-range indexes must not disturb the registers
                write_reg(REG_STEP_SIZE, {rand64()} | 64'h0000000047000000);
                write_reg(REG_STEP_SIZE, 64'h0000000047000000);
                write_reg(2'd2, rand64());
                write_reg(2'd3, rand64());
            end
            for (int n = 0; n < ((p < 10) ? phase_items[p] : 150); n++)
            begin
                if (p == 0 && n == 100)
                    hold_go <= 1'b1;
                it.sample_bits   = random_sample();
                it.element_index = $urandom();
                it.is_last       = ($urandom_range(0, 7) == 0);
                send_item(it);
            end
            drain();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/srq_pkg.sv
sv/srq_hash.sv
sv/srq_divider.sv
sv/srq_finish.sv
sv/stochastic_rounding_quantizer_unit.sv
sv/srq_checker.sv
tb/srq_code_checker.sv
tb/stochastic_rounding_quantizer_unit_tb.sv
